### rtl/mvma_pkg.sv
// Shared types, codes and binary32 helper functions for the matrix-vector accumulator.
package mvma_pkg;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ACC    = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] CFG_ROWS  = 2'd0;
  localparam logic [1:0] CFG_COLS  = 2'd1;
  localparam logic [1:0] CFG_ALPHA = 2'd2;

  localparam logic [31:0] QNAN      = 32'h7FC0_0000;
  localparam logic [31:0] INF       = 32'h7F80_0000;
  localparam logic [31:0] ALPHA_RST = 32'h3F80_0000;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef logic signed [12:0] exp_t;

  typedef struct packed {
    logic [23:0] sig;
    exp_t        e;
  } unp_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  row;
    logic [31:0] y_value;
    logic [31:0] a_value;
    logic [31:0] x_value;
    logic        last;
  } mvma_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_nan(input logic [31:0] v);
    return v[30:0] > INF[30:0];
  endfunction

  function automatic logic is_inf(input logic [31:0] v);
    return v[30:0] == INF[30:0];
  endfunction

  function automatic logic is_zero(input logic [31:0] v);
    return v[30:0] == 31'd0;
  endfunction

  // A finite nonzero value equals sig * 2^e.
  function automatic unp_t unpack(input logic [31:0] v);
    unp_t u;
    if (v[30:23] == 8'd0) begin
      u.sig = {1'b0, v[22:0]};
      u.e   = -13'sd149;
    end else begin
      u.sig = {1'b1, v[22:0]};
      u.e   = $signed({5'b0, v[30:23]}) - 13'sd150;
    end
    return u;
  endfunction

  function automatic logic [5:0] lzc64(input logic [63:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        n = 6'(63 - i);
      end
    end
    return n;
  endfunction

endpackage

### rtl/mvma_front.sv
// Front end: configuration registers, input acceptance and matrix position tracking.
module mvma_front #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_opcode,
  input  logic [9:0]           in_row,
  input  logic [31:0]          in_y_value,
  input  logic [31:0]          in_matrix_value,
  input  logic [31:0]          in_x_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output logic [31:0]          alpha,
  output logic                 push,
  output mvma_pkg::mvma_item_t item,
  input  mvma_pkg::q_stat_t    qstat
);
  import mvma_pkg::*;

  localparam int RowLimit = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;

  logic [10:0] rows_r, rows_nxt;
  logic [15:0] cols_r, cols_nxt;
  logic [31:0] alpha_r, alpha_nxt;
  logic [9:0]  row_cnt_r, row_cnt_nxt;
  logic [15:0] col_cnt_r, col_cnt_nxt;
  logic [10:0] m;
  logic [15:0] n;
  logic        row_end, col_end, accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = qstat.full;
  assign accept    = in_valid && !qstat.full;
  assign alpha     = alpha_r;

  always_comb begin
    if (rows_r == 11'd0) begin
      m = 11'd1;
    end else if (rows_r > 11'(RowLimit)) begin
      m = 11'(RowLimit);
    end else begin
      m = rows_r;
    end
    n       = (cols_r == 16'd0) ? 16'd1 : cols_r;
    row_end = {1'b0, row_cnt_r} >= (m - 11'd1);
    col_end = col_cnt_r >= (n - 16'd1);
  end

  always_comb begin
    rows_nxt    = rows_r;
    cols_nxt    = cols_r;
    alpha_nxt   = alpha_r;
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ROWS:  rows_nxt  = cfg_data[10:0];
        CFG_COLS:  cols_nxt  = cfg_data[15:0];
        CFG_ALPHA: alpha_nxt = cfg_data;
        default:   ;
      endcase
    end
    if (accept && in_opcode == OP_ACC) begin
      if (row_end) begin
        row_cnt_nxt = 10'd0;
        col_cnt_nxt = col_end ? 16'd0 : col_cnt_r + 16'd1;
      end else begin
        row_cnt_nxt = row_cnt_r + 10'd1;
      end
    end
  end

  always_comb begin
    push         = accept && (in_opcode == OP_LOAD || in_opcode == OP_ACC ||
                              in_opcode == OP_READ);
    item.op      = in_opcode;
    item.row     = (in_opcode == OP_ACC) ? row_cnt_r : in_row;
    item.y_value = in_y_value;
    item.a_value = in_matrix_value;
    item.x_value = in_x_value;
    item.last    = (in_opcode == OP_ACC) && row_end && col_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= 11'd1024;
      cols_r    <= 16'd1;
      alpha_r   <= ALPHA_RST;
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else begin
      rows_r    <= rows_nxt;
      cols_r    <= cols_nxt;
      alpha_r   <= alpha_nxt;
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
    end
  end

endmodule

### rtl/mvma_queue.sv
// Short queue that decouples the front end from the arithmetic back end.
module mvma_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mvma_pkg::mvma_item_t din,
  input  logic                 pop,
  output mvma_pkg::mvma_item_t dout,
  output mvma_pkg::q_stat_t    qstat
);
  import mvma_pkg::*;

  mvma_item_t   slot_r [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign dout        = slot_r[rptr_r];
  assign qstat.full  = cnt_r == (QAW+1)'(QDEPTH);
  assign qstat.empty = cnt_r == '0;

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

### rtl/mvma_back.sv
// Back end: y store, binary32 multiply and fused multiply-add sequencer, result register.
module mvma_back #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          alpha,
  input  mvma_pkg::mvma_item_t item,
  input  mvma_pkg::q_stat_t    qstat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [9:0]           out_row,
  output logic [31:0]          out_value,
  output logic                 out_done_res
);
  import mvma_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_RDOUT = 10'b00_0000_0010,
    ST_MUL   = 10'b00_0000_0100,
    ST_NORM  = 10'b00_0000_1000,
    ST_RND   = 10'b00_0001_0000,
    ST_FMUL  = 10'b00_0010_0000,
    ST_ALN   = 10'b00_0100_0000,
    ST_SHF   = 10'b00_1000_0000,
    ST_ADD   = 10'b01_0000_0000,
    ST_FIN   = 10'b10_0000_0000
  } st_t;

  logic [31:0] y_mem [MAX_ROWS];

  st_t         st_r, st_nxt;
  mvma_item_t  cur_r, cur_nxt;
  logic        row_ok_r, row_ok_nxt;
  logic [31:0] rd_data_r;
  logic [31:0] t_r, t_nxt, res_r, res_nxt;
  logic        phase_r, phase_nxt;
  logic        rp_sign_r, rp_sign_nxt;
  exp_t        rp_e_r, rp_e_nxt;
  logic [63:0] rp_sig_r, rp_sig_nxt;
  logic [63:0] p_r, p_nxt, q_r, q_nxt;
  exp_t        ep_r, ep_nxt, ec_r, ec_nxt;
  logic        ps_r, ps_nxt, cs_r, cs_nxt;
  logic [63:0] big_r, big_nxt, sml_r, sml_nxt;
  exp_t        eb_r, eb_nxt;
  logic        sgn_r, sgn_nxt;
  logic        out_valid_r, out_valid_nxt, out_done_r, out_done_nxt;
  logic [9:0]  out_row_r, out_row_nxt;
  logic [31:0] out_value_r, out_value_nxt;

  logic          head_ok, out_free, mem_we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata, yv, mul_a, mul_b, rnd_val;
  logic [47:0]   prod;
  unp_t          ua, ub;

  assign head_ok   = {22'b0, item.row} < 32'(MAX_ROWS);
  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = (st_r == ST_IDLE) && !qstat.empty;
  assign yv        = row_ok_r ? rd_data_r : 32'd0;
  assign out_valid    = out_valid_r;
  assign out_row      = out_row_r;
  assign out_value    = out_value_r;
  assign out_done_res = out_done_r;

  // One shared 24 by 24 multiplier for alpha*x and t*a.
  always_comb begin
    mul_a = (st_r == ST_MUL) ? alpha : t_r;
    mul_b = (st_r == ST_MUL) ? cur_r.x_value : cur_r.a_value;
    ua    = unpack(mul_a);
    ub    = unpack(mul_b);
    prod  = ua.sig * ub.sig;
  end

  // Rounding to binary32, nearest even, from a normalised significand.
  always_comb begin
    exp_t        s;
    logic [6:0]  s7;
    logic [127:0] wide;
    logic [24:0] m25;
    logic [7:0]  field;
    logic [31:0] bits;
    s     = 13'sd40;
    field = 8'd0;
    if (rp_e_r >= 13'sd1) begin
      field = rp_e_r[7:0] - 8'd1;
    end else begin
      s = 13'sd41 - rp_e_r;
    end
    s7   = (s > 13'sd127) ? 7'd127 : s[6:0];
    wide = {rp_sig_r, 64'd0} >> s7;
    m25  = wide[88:64];
    m25  = m25 + 25'(wide[63] && ((|wide[62:0]) || m25[0]));
    bits = {1'b0, field, 23'd0} + {7'd0, m25};
    if (bits >= INF) begin
      bits = INF;
    end
    if (rp_e_r > 13'sd254) begin
      rnd_val = {rp_sign_r, INF[30:0]};
    end else begin
      rnd_val = {rp_sign_r, bits[30:0]};
    end
  end

  always_comb begin
    logic [5:0]  lz, lzp, lzq;
    logic        p_ge;
    exp_t        d;
    logic [63:0] bv, sv, mask, sum;
    logic        sa;
    unp_t        uq;
    lz   = lzc64(rp_sig_r);
    lzp  = lzc64(p_r);
    lzq  = lzc64(q_r);
    p_ge = 1'b0;
    d    = '0;
    bv   = '0;
    sv   = '0;
    mask = '0;
    sum  = '0;
    sa   = 1'b0;
    uq   = unpack(yv);

    st_nxt      = st_r;
    cur_nxt     = cur_r;
    row_ok_nxt  = row_ok_r;
    t_nxt       = t_r;
    res_nxt     = res_r;
    phase_nxt   = phase_r;
    rp_sign_nxt = rp_sign_r;
    rp_e_nxt    = rp_e_r;
    rp_sig_nxt  = rp_sig_r;
    p_nxt       = p_r;
    q_nxt       = q_r;
    ep_nxt      = ep_r;
    ec_nxt      = ec_r;
    ps_nxt      = ps_r;
    cs_nxt      = cs_r;
    big_nxt     = big_r;
    sml_nxt     = sml_r;
    eb_nxt      = eb_r;
    sgn_nxt     = sgn_r;
    mem_we      = 1'b0;
    waddr       = AW'(item.row);
    wdata       = item.y_value;
    out_valid_nxt = out_valid_r && out_stall;
    out_row_nxt   = out_row_r;
    out_value_nxt = out_value_r;
    out_done_nxt  = out_done_r;

    case (st_r)
      ST_IDLE: begin
        if (pop) begin
          cur_nxt    = item;
          row_ok_nxt = head_ok;
          case (item.op)
            OP_LOAD: mem_we = head_ok;
            OP_READ: st_nxt = ST_RDOUT;
            OP_ACC:  st_nxt = ST_MUL;
            default: ;
          endcase
        end
      end
      ST_RDOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = cur_r.row;
          out_value_nxt = yv;
          out_done_nxt  = 1'b0;
          st_nxt        = ST_IDLE;
        end
      end
      ST_MUL: begin
        sa        = mul_a[31] ^ mul_b[31];
        phase_nxt = 1'b0;
        if (is_nan(mul_a) || is_nan(mul_b)) begin
          t_nxt  = QNAN;
          st_nxt = ST_FMUL;
        end else if (is_inf(mul_a) || is_inf(mul_b)) begin
          t_nxt  = (is_zero(mul_a) || is_zero(mul_b)) ? QNAN : {sa, INF[30:0]};
          st_nxt = ST_FMUL;
        end else if (is_zero(mul_a) || is_zero(mul_b)) begin
          t_nxt  = {sa, 31'd0};
          st_nxt = ST_FMUL;
        end else begin
          rp_sign_nxt = sa;
          rp_e_nxt    = ua.e + ub.e;
          rp_sig_nxt  = {16'd0, prod};
          st_nxt      = ST_NORM;
        end
      end
      ST_NORM: begin
        rp_sig_nxt = rp_sig_r << lz;
        rp_e_nxt   = rp_e_r + 13'sd190 - $signed({7'd0, lz});
        st_nxt     = ST_RND;
      end
      ST_RND: begin
        if (phase_r) begin
          res_nxt = rnd_val;
          st_nxt  = ST_FIN;
        end else begin
          t_nxt  = rnd_val;
          st_nxt = ST_FMUL;
        end
      end
      ST_FMUL: begin
        sa        = mul_a[31] ^ mul_b[31];
        phase_nxt = 1'b1;
        st_nxt    = ST_FIN;
        if (is_nan(mul_a) || is_nan(mul_b) || is_nan(yv)) begin
          res_nxt = QNAN;
        end else if (is_inf(mul_a) || is_inf(mul_b)) begin
          if (is_zero(mul_a) || is_zero(mul_b)) begin
            res_nxt = QNAN;
          end else if (is_inf(yv) && yv[31] != sa) begin
            res_nxt = QNAN;
          end else begin
            res_nxt = {sa, INF[30:0]};
          end
        end else if (is_inf(yv)) begin
          res_nxt = yv;
        end else if (is_zero(mul_a) || is_zero(mul_b)) begin
          if (is_zero(yv)) begin
            res_nxt = (sa == yv[31]) ? {sa, 31'd0} : 32'd0;
          end else begin
            res_nxt = yv;
          end
        end else if (is_zero(yv)) begin
          rp_sign_nxt = sa;
          rp_e_nxt    = ua.e + ub.e;
          rp_sig_nxt  = {16'd0, prod};
          st_nxt      = ST_NORM;
        end else begin
          p_nxt  = {16'd0, prod};
          ep_nxt = ua.e + ub.e;
          q_nxt  = {40'd0, uq.sig};
          ec_nxt = uq.e;
          ps_nxt = sa;
          cs_nxt = yv[31];
          st_nxt = ST_ALN;
        end
      end
      ST_ALN: begin
        // Both significands are brought to bit 61 before alignment.
        p_nxt  = p_r << (lzp - 6'd2);
        ep_nxt = ep_r - $signed({7'd0, lzp - 6'd2});
        q_nxt  = q_r << (lzq - 6'd2);
        ec_nxt = ec_r - $signed({7'd0, lzq - 6'd2});
        st_nxt = ST_SHF;
      end
      ST_SHF: begin
        p_ge = (ep_r > ec_r) || (ep_r == ec_r && p_r >= q_r);
        if (p_ge) begin
          bv = p_r; sv = q_r; eb_nxt = ep_r; d = ep_r - ec_r; sgn_nxt = ps_r;
        end else begin
          bv = q_r; sv = p_r; eb_nxt = ec_r; d = ec_r - ep_r; sgn_nxt = cs_r;
        end
        if (d >= 13'sd62) begin
          sv = 64'd1;
        end else if (d > 13'sd0) begin
          mask = ~({64{1'b1}} << d[5:0]);
          sv   = (sv >> d[5:0]) | 64'(|(sv & mask));
        end
        big_nxt = bv;
        sml_nxt = sv;
        st_nxt  = ST_ADD;
      end
      ST_ADD: begin
        sum = (ps_r == cs_r) ? big_r + sml_r : big_r - sml_r;
        if (sum == 64'd0) begin
          res_nxt = 32'd0;
          st_nxt  = ST_FIN;
        end else begin
          rp_sign_nxt = sgn_r;
          rp_e_nxt    = eb_r;
          rp_sig_nxt  = sum;
          st_nxt      = ST_NORM;
        end
      end
      ST_FIN: begin
        waddr = AW'(cur_r.row);
        wdata = res_r;
        if (!cur_r.last || out_free) begin
          mem_we = row_ok_r;
          st_nxt = ST_IDLE;
          if (cur_r.last) begin
            out_valid_nxt = 1'b1;
            out_row_nxt   = cur_r.row;
            out_value_nxt = res_r;
            out_done_nxt  = 1'b1;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data_r <= y_mem[AW'(item.row)];
    end
    if (mem_we) begin
      y_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    row_ok_r    <= row_ok_nxt;
    t_r         <= t_nxt;
    res_r       <= res_nxt;
    phase_r     <= phase_nxt;
    rp_sign_r   <= rp_sign_nxt;
    rp_e_r      <= rp_e_nxt;
    rp_sig_r    <= rp_sig_nxt;
    p_r         <= p_nxt;
    q_r         <= q_nxt;
    ep_r        <= ep_nxt;
    ec_r        <= ec_nxt;
    ps_r        <= ps_nxt;
    cs_r        <= cs_nxt;
    big_r       <= big_nxt;
    sml_r       <= sml_nxt;
    eb_r        <= eb_nxt;
    sgn_r       <= sgn_nxt;
    out_row_r   <= out_row_nxt;
    out_value_r <= out_value_nxt;
    out_done_r  <= out_done_nxt;
  end

endmodule

### rtl/matrix_vector_multiply_accumulate.sv
// Top level of the single-precision y = y + alpha*A*x accumulator.
//
// Usage. The input channel carries one beat per operation: opcode 0 loads y[row]
// with y_value, opcode 1 accumulates one element of A (column-major) together with
// the x value of its column, opcode 2 reads y[row]. Opcode 3 is dropped. The block
// keeps its own row and column position for the matrix stream. The result channel
// returns a beat for every read, and one beat with done set after the last element
// of the last column, carrying that element's row and its final y value.
// The configuration channel (always ready) sets the row count, column count and
// alpha; the user must write it only while the block is idle, which is not enforced.
// Timing. A four-entry queue sits between the front end and the arithmetic unit, so
// beats are taken while earlier work is in progress, until the queue fills. The
// arithmetic unit handles one operation at a time; an accumulate passes through the
// multiply, normalise and round steps of the sequencer, which share one multiplier
// and one rounder.
// Reset is synchronous: counters clear, registers take their defaults, the queue
// empties and no result is shown. The y store is not cleared. While the receiver
// stalls, the result beat holds and the queue fills, then in_stall rises.
module matrix_vector_multiply_accumulate #(
  parameter int MAX_ROWS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [9:0]  in_row,
  input  logic [31:0] in_y_value,
  input  logic [31:0] in_matrix_value,
  input  logic [31:0] in_x_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_row,
  output logic [31:0] out_value,
  output logic        out_done_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mvma_pkg::*;

  logic       push, pop;
  logic [31:0] alpha;
  mvma_item_t in_item, head_item;
  q_stat_t    qstat;

  // The front end tracks the matrix position so the back end never has to.
  mvma_front #(.MAX_ROWS(MAX_ROWS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_row, .in_y_value,
    .in_matrix_value, .in_x_value, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .alpha, .push, .item(in_item), .qstat
  );

  mvma_queue u_queue (
    .clk, .rst_n, .push, .din(in_item), .pop, .dout(head_item), .qstat
  );

  // The back end pops one operation at a time, so y updates stay in order.
  mvma_back #(.MAX_ROWS(MAX_ROWS)) u_back (
    .clk, .rst_n, .alpha, .item(head_item), .qstat, .pop, .out_valid, .out_stall,
    .out_row, .out_value, .out_done_res
  );

endmodule

### rtl/mvma_checker.sv
// Port-level checks for the matrix-vector accumulator, bound to the top level.
module mvma_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [9:0]  out_row,
  input logic [31:0] out_value,
  input logic        out_done_res
);

  a_reset_no_result: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_reset_queue_open: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled straight after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result withdrawn");

  a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_row) && $stable(out_value) &&
    $stable(out_done_res))
    else $error("stalled result changed");

endmodule

bind matrix_vector_multiply_accumulate mvma_checker u_mvma_checker (.*);

### dv/testbench.sv
// Self-checking testbench for the binary32 matrix-vector multiply-accumulate block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mvma_pkg::*;

  localparam int Y_DEPTH     = 1024;
  localparam int CYCLE_LIMIT = 1_000_000;
  // Long enough for a full queue of accumulates to drain through the sequencer.
  localparam int SETTLE      = 60;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [9:0]  in_row;
  logic [31:0] in_y_value;
  logic [31:0] in_matrix_value;
  logic [31:0] in_x_value;
  logic        out_valid;
  logic        out_stall;
  logic [9:0]  out_row;
  logic [31:0] out_value;
  logic        out_done_res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  typedef struct packed {
    logic [9:0]  row;
    logic [31:0] value;
    logic        done;
  } y_report_t;

  // Reports the block owes us, oldest first.
  y_report_t y_reports_due[$];

  // Our own copy of the block's registers and accumulator state.
  logic [10:0] rows_reg;
  logic [15:0] cols_reg;
  logic [31:0] alpha_reg;
  logic [31:0] y_mirror [Y_DEPTH];
  bit          y_written [Y_DEPTH];
  logic [9:0]  row_pos;
  logic [15:0] col_pos;

  int  errors;
  int  beats_sent;
  int  cycles;
  bit  calm;
  int  stall_left;

  matrix_vector_multiply_accumulate uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode), .in_row(in_row),
    .in_y_value(in_y_value), .in_matrix_value(in_matrix_value), .in_x_value(in_x_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_row(out_row),
    .out_value(out_value), .out_done_res(out_done_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Binary32 arithmetic, carried out on integers with round-to-nearest-even.
  // ---------------------------------------------------------------------------
  function automatic bit f_nan(logic [31:0] v);
    return v[30:0] > 31'h7F80_0000;
  endfunction

  function automatic bit f_inf(logic [31:0] v);
    return v[30:0] == 31'h7F80_0000;
  endfunction

  function automatic bit f_zero(logic [31:0] v);
    return v[30:0] == 31'd0;
  endfunction

  // Splits a finite nonzero value into an integer significand and a power of two.
  function automatic void split_f(logic [31:0] v, output logic [63:0] sig, output int e);
    if (v[30:23] == 8'd0) begin
      sig = {41'd0, v[22:0]};
      e   = -149;
    end else begin
      sig = {40'd0, 1'b1, v[22:0]};
      e   = int'(v[30:23]) - 150;
    end
  endfunction

  // Rounds sgn * sig * 2^e (sig nonzero) to the nearest binary32, ties to even.
  function automatic logic [31:0] round_f(bit sgn, int e, logic [63:0] sig);
    int          biased;
    int          s;
    logic [31:0] fld;
    logic [31:0] bits;
    logic [63:0] m;
    logic [63:0] rem;
    logic [63:0] half;
    while (!sig[63]) begin
      sig = sig << 1;
      e--;
    end
    biased = e + 63 + 127;
    if (biased > 254) return {sgn, 31'h7F80_0000};
    if (biased >= 1) begin
      s   = 40;
      fld = biased - 1;
    end else begin
      s   = 41 - biased;
      fld = 0;
    end
    if (s >= 64) begin
      m = (s == 64 && sig > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
    end else begin
      rem  = sig & ((64'd1 << s) - 64'd1);
      half = 64'd1 << (s - 1);
      m    = sig >> s;
      if (rem > half || (rem == half && m[0])) m++;
    end
    bits = (fld << 23) + m[31:0];
    if (bits >= 32'h7F80_0000) bits = 32'h7F80_0000;
    return {sgn, bits[30:0]};
  endfunction

  function automatic logic [31:0] mul_f(logic [31:0] a, logic [31:0] b);
    bit          sgn;
    logic [63:0] sa;
    logic [63:0] sb;
    int          ea;
    int          eb;
    sgn = a[31] ^ b[31];
    if (f_nan(a) || f_nan(b)) return QNAN;
    if (f_inf(a) || f_inf(b)) begin
      if (f_zero(a) || f_zero(b)) return QNAN;
      return {sgn, 31'h7F80_0000};
    end
    if (f_zero(a) || f_zero(b)) return {sgn, 31'd0};
    split_f(a, sa, ea);
    split_f(b, sb, eb);
    return round_f(sgn, ea + eb, sa * sb);
  endfunction

  // a * b + c with a single rounding.
  function automatic logic [31:0] fused_f(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    bit          ps;
    bit          cs;
    bit          sgn;
    logic [63:0] sa;
    logic [63:0] sb;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] big;
    logic [63:0] lesser;
    logic [63:0] sum;
    int          ea;
    int          eb;
    int          ep;
    int          ec;
    int          e_big;
    int          d;
    ps = a[31] ^ b[31];
    cs = c[31];
    if (f_nan(a) || f_nan(b) || f_nan(c)) return QNAN;
    if (f_inf(a) || f_inf(b)) begin
      if (f_zero(a) || f_zero(b)) return QNAN;
      if (f_inf(c) && cs != ps) return QNAN;
      return {ps, 31'h7F80_0000};
    end
    if (f_inf(c)) return c;
    if (f_zero(a) || f_zero(b)) begin
      if (f_zero(c)) return (ps == cs) ? {ps, 31'd0} : 32'd0;
      return c;
    end
    split_f(a, sa, ea);
    split_f(b, sb, eb);
    p  = sa * sb;
    ep = ea + eb;
    if (f_zero(c)) return round_f(ps, ep, p);
    split_f(c, q, ec);
    while (!p[61]) begin
      p = p << 1;
      ep--;
    end
    while (!q[61]) begin
      q = q << 1;
      ec--;
    end
    if (ep > ec || (ep == ec && p >= q)) begin
      big = p; lesser = q; e_big = ep; d = ep - ec; sgn = ps;
    end else begin
      big = q; lesser = p; e_big = ec; d = ec - ep; sgn = cs;
    end
    // Alignment keeps a sticky bit for everything shifted out.
    if (d >= 62) begin
      lesser = 64'd1;
    end else if (d > 0) begin
      lesser = (lesser >> d) | ((lesser & ((64'd1 << d) - 64'd1)) != 0 ? 64'd1 : 64'd0);
    end
    sum = (ps == cs) ? big + lesser : big - lesser;
    if (sum == 0) return 32'd0;
    return round_f(sgn, e_big, sum);
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction of one accepted beat.
  // ---------------------------------------------------------------------------
  task automatic predict_beat(logic [1:0] op, logic [9:0] row, logic [31:0] yv,
                              logic [31:0] av, logic [31:0] xv);
    int          m;
    int          n;
    logic [9:0]  r;
    logic [31:0] res;
    y_report_t   rep;
    case (op)
      OP_LOAD: begin
        y_mirror[row]  = yv;
        y_written[row] = 1'b1;
      end
      OP_READ: begin
        rep.row   = row;
        rep.value = y_mirror[row];
        rep.done  = 1'b0;
        y_reports_due.push_back(rep);
      end
      OP_ACC: begin
        // Row count is clamped to one store's worth, a column count of zero means one.
        m = (rows_reg < 1) ? 1 : (rows_reg > Y_DEPTH) ? Y_DEPTH : int'(rows_reg);
        n = (cols_reg == 0) ? 1 : int'(cols_reg);
        r = row_pos;
        res = fused_f(mul_f(alpha_reg, xv), av, y_mirror[r]);
        y_mirror[r] = res;
        // Limits are tested with "at or above" so that stale counters end their column.
        if (int'(row_pos) >= m - 1) begin
          if (int'(col_pos) >= n - 1) begin
            row_pos = '0;
            col_pos = '0;
            rep.row   = r;
            rep.value = res;
            rep.done  = 1'b1;
            y_reports_due.push_back(rep);
          end else begin
            row_pos = '0;
            col_pos = col_pos + 16'd1;
          end
        end else begin
          row_pos = row_pos + 10'd1;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers shared by the tests.
  // ---------------------------------------------------------------------------

  // Presents one beat, waits for it to be taken, then perhaps leaves a gap.
  // Valid is left high after a beat so back-to-back beats really are back to back.
  task automatic send_beat(logic [1:0] op, logic [9:0] row, logic [31:0] yv,
                           logic [31:0] av, logic [31:0] xv);
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_row          <= row;
    in_y_value      <= yv;
    in_matrix_value <= av;
    in_x_value      <= xv;
    do @(posedge clk); while (in_stall);
    predict_beat(op, row, yv, av, xv);
    beats_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Drops valid and waits until every report has arrived and the sequencer has settled.
  task automatic drain;
    in_valid <= 1'b0;
    while (y_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register writes only ever happen after a drain.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ROWS:  rows_reg  = data[10:0];
      CFG_COLS:  cols_reg  = data[15:0];
      CFG_ALPHA: alpha_reg = data;
      default: ;
    endcase
  endtask

  // Random binary32 pattern, weighted towards the awkward classes.
  function automatic logic [31:0] pick_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 11))
      0: v = {v[31], 31'd0};
      1: v = {v[31], 31'h7F80_0000};
      2: v = {v[31], 8'hFF, v[22:0] | 23'd1};
      3: v = {v[31], 8'd0, v[22:0]};
      4, 5, 6, 7: v = {v[31], 8'(8'd120 + $urandom_range(0, 14)), v[22:0]};
      default: ;
    endcase
    return v;
  endfunction

  // Loads fresh values into y[0 .. count-1].
  task automatic load_rows(int count);
    for (int i = 0; i < count; i++) send_beat(OP_LOAD, 10'(i), pick_float(), $urandom, $urandom);
  endtask

  // Streams a whole matrix of rows x cols random elements.
  task automatic run_pass(int rows, int cols);
    logic [31:0] xv;
    for (int c = 0; c < cols; c++) begin
      xv = pick_float();
      for (int r = 0; r < rows; r++) begin
        send_beat(OP_ACC, 10'($urandom), $urandom, pick_float(), xv);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Loads at both ends of the store, reads them back, and an unused opcode.
  task automatic test_load_read;
    send_beat(OP_LOAD, 10'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_LOAD, 10'd1023, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_beat(OP_READ, 10'd1023, $urandom, $urandom, $urandom);
    send_beat(OP_READ, 10'd0, $urandom, $urandom, $urandom);
    send_beat(OP_UNUSED, 10'd0, $urandom, $urandom, $urandom);
    send_beat(OP_READ, 10'd0, $urandom, $urandom, $urandom);
    drain();
  endtask

  // Single-element passes through zeros, infinities, NaNs, subnormals and overflow.
  task automatic test_special_values;
    logic [31:0] cases [10][3];
    cases = '{
      '{32'h7F80_0000, 32'h0000_0000, 32'h3F80_0000},   // inf * 0
      '{32'h7F80_0000, 32'h3F80_0000, 32'hFF80_0000},   // inf - inf
      '{32'h7FC0_1234, 32'h3F80_0000, 32'h3F80_0000},   // NaN in
      '{32'h8000_0000, 32'h3F80_0000, 32'h8000_0000},   // signed zeros
      '{32'h8000_0000, 32'h3F80_0000, 32'h0000_0000},
      '{32'h0000_0001, 32'h3F00_0000, 32'h0000_0001},   // subnormal tie
      '{32'h7F7F_FFFF, 32'h4000_0000, 32'h0000_0000},   // overflow
      '{32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000},   // exact cancellation
      '{32'h3F80_0001, 32'h3F80_0001, 32'hBF80_0002},   // fused keeps low bits
      '{32'h0080_0000, 32'h3F00_0000, 32'h8000_0001}    // into the subnormal range
    };
    write_reg(CFG_ROWS, 32'd1);
    write_reg(CFG_COLS, 32'd1);
    for (int i = 0; i < 10; i++) begin
      send_beat(OP_LOAD, 10'd0, cases[i][2], $urandom, $urandom);
      send_beat(OP_ACC, 10'($urandom), $urandom, cases[i][1], cases[i][0]);
    end
    drain();
  endtask

  // Out-of-range register values and the extreme alphas.
  task automatic test_register_limits;
    write_reg(CFG_ROWS, 32'd0);      // clamps to one row
    write_reg(CFG_COLS, 32'd0);      // acts as one column
    write_reg(CFG_ALPHA, 32'hFFFF_FFFF);
    load_rows(2);
    run_pass(1, 1);
    drain();
    write_reg(CFG_ALPHA, 32'h0000_0000);
    run_pass(1, 1);
    drain();
    write_reg(CFG_ROWS, 32'd3);
    write_reg(CFG_COLS, 32'd2);
    write_reg(CFG_ALPHA, 32'h4000_0000);
    load_rows(3);
    run_pass(3, 2);
    drain();
  endtask

  // Counters left beyond the limits by a register change end the column or the pass.
  task automatic test_stale_counters;
    write_reg(CFG_ROWS, 32'd8);
    write_reg(CFG_COLS, 32'd2);
    load_rows(8);
    run_pass(5, 1);
    drain();
    write_reg(CFG_ROWS, 32'd3);      // row 5 now ends its column
    run_pass(1, 1);
    run_pass(3, 1);                  // second column ends the pass
    drain();
    write_reg(CFG_ROWS, 32'd1);
    write_reg(CFG_COLS, 32'd65535);
    run_pass(1, 3);
    drain();
    write_reg(CFG_COLS, 32'd1);      // column count 3 lies beyond, so this ends it
    run_pass(1, 1);
    drain();
  endtask

  // A single column over the whole store, with a row count above the clamp.
  task automatic test_full_height;
    write_reg(CFG_ROWS, 32'd2047);
    write_reg(CFG_COLS, 32'd1);
    write_reg(CFG_ALPHA, pick_float());
    load_rows(Y_DEPTH);
    run_pass(Y_DEPTH, 1);
    drain();
  endtask

  // Mostly well-formed passes with random shapes, with reads and stray beats between.
  task automatic test_random_passes(int budget);
    int rows;
    int cols;
    int row;
    while (beats_sent < budget) begin
      // The last stretch runs without any idling on either side.
      if (beats_sent > budget - 200) calm = 1'b1;
      rows = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
      cols = $urandom_range(1, 5);
      write_reg(CFG_ROWS, rows);
      write_reg(CFG_COLS, cols);
      write_reg(CFG_ALPHA, pick_float());
      load_rows(rows);
      run_pass(rows, cols);
      for (int k = $urandom_range(0, 4); k > 0; k--) begin
        row = $urandom_range(0, Y_DEPTH - 1);
        case ($urandom_range(0, 2))
          0: send_beat(OP_LOAD, 10'(row), pick_float(), $urandom, $urandom);
          1: if (y_written[row]) send_beat(OP_READ, 10'(row), $urandom, $urandom, $urandom);
          default: send_beat(OP_UNUSED, 10'($urandom), $urandom, $urandom, $urandom);
        endcase
      end
      drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: every accepted beat is matched against the oldest report due.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    y_report_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (y_reports_due.size() == 0) begin
        $display("%0t: unexpected result beat: row %0d value %h done %b",
                 $time, out_row, out_value, out_done_res);
        errors++;
      end else begin
        due = y_reports_due.pop_front();
        if (out_row !== due.row) begin
          $display("%0t: out_row expected %0d actual %0d", $time, due.row, out_row);
          errors++;
        end
        if (out_value !== due.value) begin
          $display("%0t: out_value expected %h actual %h", $time, due.value, out_value);
          errors++;
        end
        if (out_done_res !== due.done) begin
          $display("%0t: out_done_res expected %b actual %b", $time, due.done, out_done_res);
          errors++;
        end
      end
    end
  end

  // The receiver stalls in bursts, and not at all once things have calmed down.
  always @(posedge clk) begin
    if (calm || !rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    errors          = 0;
    beats_sent      = 0;
    cycles          = 0;
    calm            = 1'b0;
    stall_left      = 0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = OP_LOAD;
    in_row          = '0;
    in_y_value      = '0;
    in_matrix_value = '0;
    in_x_value      = '0;
    out_stall       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_ROWS;
    cfg_data        = '0;
    rows_reg        = 11'd1024;
    cols_reg        = 16'd1;
    alpha_reg       = ALPHA_RST;
    row_pos         = '0;
    col_pos         = '0;
    for (int i = 0; i < Y_DEPTH; i++) begin
      y_mirror[i]  = '0;
      y_written[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_read();
    test_special_values();
    test_register_limits();
    test_stale_counters();
    test_full_height();
    test_random_passes(beats_sent + 300);
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
